/* hdl/vbi_pkg.sv */
`default_nettype none
package vbi_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_FORCE          = 3'd0;
  localparam logic [2:0] KIND_IMPULSE        = 3'd1;
  localparam logic [2:0] KIND_TORQUE_FORCE   = 3'd2;
  localparam logic [2:0] KIND_TORQUE_IMPULSE = 3'd3;
  localparam logic [2:0] KIND_TICK           = 3'd4;
  localparam logic [2:0] KIND_MOVE           = 3'd5;
  localparam logic [2:0] KIND_TELEPORT       = 3'd6;

  localparam logic [2:0] OP_LIN      = 3'd0;
  localparam logic [2:0] OP_ANG      = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_MOVE     = 3'd3;
  localparam logic [2:0] OP_TELEPORT = 3'd4;

  localparam logic [1:0] REG_INVERSE_MASS     = 2'd0;
  localparam logic [1:0] REG_MAX_ANGULAR_STEP = 2'd1;
  localparam logic [1:0] REG_PHYSICS_ENABLED  = 2'd2;

  localparam logic [24:0] DEG360 = 25'd23592960;
  localparam logic [24:0] DEG180 = 25'd11796480;
  localparam logic [16:0] ONE_SECOND = 17'd65536;
  localparam logic [16:0] STILL_MAX = 17'd131071;
  localparam logic [25:0] RECIP_MASS_RESET = 26'd65536;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [15:0]        dt;
  } item_t;

  typedef struct packed {
    logic [25:0] recip_mass;
    logic [24:0] max_step;
    logic        enabled;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/vbi_front.sv */
`default_nettype none
module vbi_front import vbi_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  item_t          item;
  logic           keep, push, pop;

  always_comb begin
    keep = 1'b1;
    item.vx = $signed(in_tdata[31:0]);
    item.vy = $signed(in_tdata[63:32]);
    item.dt = in_tdata[79:64];
    item.op = OP_LIN;
    unique case (in_tuser)
      KIND_FORCE, KIND_IMPULSE: item.op = OP_LIN;
      KIND_TORQUE_FORCE, KIND_TORQUE_IMPULSE: item.op = OP_ANG;
      KIND_TICK: item.op = OP_TICK;
      KIND_MOVE: item.op = OP_MOVE;
      KIND_TELEPORT: item.op = OP_TELEPORT;
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = (count_r != CW'(DEPTH));
  assign push = in_tvalid && in_tready && keep;
  assign q_valid = (count_r != '0);
  assign pop = q_pop && q_valid;
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= item;
  end

endmodule
`default_nettype wire

/* hdl/vbi_back.sv */
`default_nettype none
module vbi_back import vbi_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         q_valid,
  input  wire item_t        q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_DMUL  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_WRAP  = 3'd6;

  localparam logic signed [35:0] ANGLE_BIAS = 36'sd3019898880;
  // 360 degrees in Q9.16 is 45 * 2^19; the quotient by 45 uses ceil(2^20 / 45).
  localparam logic [14:0] RECIP45 = 15'd23302;

  logic [2:0] state_r, state_nxt;
  logic signed [31:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [31:0] old_x_r, old_x_nxt, old_y_r, old_y_nxt;
  logic [24:0] ang_now_r, ang_now_nxt, ang_prev_r, ang_prev_nxt;
  logic signed [31:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt, sum_a_r, sum_a_nxt;
  logic signed [31:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [16:0] still_r, still_nxt;
  logic moving_r, moving_nxt;

  logic signed [58:0] prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt, prod_a_r, prod_a_nxt;
  logic [31:0] dt2_r, dt2_nxt;
  logic signed [25:0] step_r, step_nxt;
  logic signed [31:0] ang_acc_r, ang_acc_nxt;
  logic signed [64:0] dp_x_r, dp_x_nxt, dp_y_r, dp_y_nxt, dp_a_r, dp_a_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [9:0] quot_r, quot_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [159:0] out_data_r, out_data_nxt;

  logic signed [25:0] raw_step, red_step, lim;
  logic [17:0] still_sum;
  logic [16:0] still_new;
  logic signed [59:0] rnd_x, rnd_y, rnd_a;
  logic signed [65:0] rd_x, rd_y, rd_a;
  logic signed [35:0] o_sum;
  logic [29:0] quot_prod;
  logic [34:0] wrap_prod;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    raw_step = $signed({1'b0, ang_now_r}) - $signed({1'b0, ang_prev_r});
    if (raw_step > $signed({1'b0, DEG180})) red_step = raw_step - $signed({1'b0, DEG360});
    else if (raw_step <= -$signed({1'b0, DEG180}))
      red_step = raw_step + $signed({1'b0, DEG360});
    else red_step = raw_step;
    lim = $signed({1'b0, cfg.max_step});
    still_sum = {1'b0, still_r} + {2'd0, q_item.dt};
    still_new = (still_sum > {1'b0, STILL_MAX}) ? STILL_MAX : still_sum[16:0];
    rnd_x = {prod_x_r[58], prod_x_r} + 60'sd32768;
    rnd_y = {prod_y_r[58], prod_y_r} + 60'sd32768;
    rnd_a = {prod_a_r[58], prod_a_r} + 60'sd32768;
    rd_x = {dp_x_r[64], dp_x_r} + 66'sd2147483648;
    rd_y = {dp_y_r[64], dp_y_r} + 66'sd2147483648;
    rd_a = {dp_a_r[64], dp_a_r} + 66'sd2147483648;
    o_sum = $signed({11'd0, ang_now_r}) + {{10{step_r[25]}}, step_r}
          + {{2{rd_a[65]}}, rd_a[65:32]} + ANGLE_BIAS;
    quot_prod = {15'd0, rem_r[33:19]} * {15'd0, RECIP45};
    wrap_prod = {25'd0, quot_r} * {10'd0, DEG360};
  end

  always_comb begin
    state_nxt = state_r;
    cur_x_nxt = cur_x_r; cur_y_nxt = cur_y_r;
    old_x_nxt = old_x_r; old_y_nxt = old_y_r;
    ang_now_nxt = ang_now_r; ang_prev_nxt = ang_prev_r;
    sum_x_nxt = sum_x_r; sum_y_nxt = sum_y_r; sum_a_nxt = sum_a_r;
    acc_x_nxt = acc_x_r; acc_y_nxt = acc_y_r;
    still_nxt = still_r; moving_nxt = moving_r;
    prod_x_nxt = prod_x_r; prod_y_nxt = prod_y_r; prod_a_nxt = prod_a_r;
    dt2_nxt = dt2_r; step_nxt = step_r; ang_acc_nxt = ang_acc_r;
    dp_x_nxt = dp_x_r; dp_y_nxt = dp_y_r; dp_a_nxt = dp_a_r;
    rem_nxt = rem_r; quot_nxt = quot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    q_pop = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_LIN: begin
              sum_x_nxt = sat32({{34{sum_x_r[31]}}, sum_x_r} + {{34{q_item.vx[31]}}, q_item.vx});
              sum_y_nxt = sat32({{34{sum_y_r[31]}}, sum_y_r} + {{34{q_item.vy[31]}}, q_item.vy});
              moving_nxt = 1'b1;
            end
            OP_ANG: begin
              sum_a_nxt = sat32({{34{sum_a_r[31]}}, sum_a_r} + {{34{q_item.vx[31]}}, q_item.vx});
              moving_nxt = 1'b1;
            end
            OP_MOVE: begin
              moving_nxt = 1'b1;
              cur_x_nxt = q_item.vx;
              cur_y_nxt = q_item.vy;
            end
            OP_TELEPORT: begin
              cur_x_nxt = q_item.vx; old_x_nxt = q_item.vx;
              cur_y_nxt = q_item.vy; old_y_nxt = q_item.vy;
            end
            OP_TICK: begin
              sum_x_nxt = '0; sum_y_nxt = '0; sum_a_nxt = '0;
              if (!moving_r || !cfg.enabled || cfg.recip_mass == '0) begin
                state_nxt = S_EMIT;
              end else begin
                prod_x_nxt = sum_x_r * $signed({1'b0, cfg.recip_mass});
                prod_y_nxt = sum_y_r * $signed({1'b0, cfg.recip_mass});
                prod_a_nxt = sum_a_r * $signed({1'b0, cfg.recip_mass});
                dt2_nxt = {16'd0, q_item.dt} * {16'd0, q_item.dt};
                if (red_step > lim) step_nxt = lim;
                else if (red_step < -lim) step_nxt = -lim;
                else step_nxt = red_step;
                if (cur_x_r == old_x_r && cur_y_r == old_y_r && red_step == '0)
                  still_nxt = still_new;
                else still_nxt = '0;
                moving_nxt = ((cur_x_r == old_x_r && cur_y_r == old_y_r && red_step == '0)
                             ? still_new : 17'd0) < ONE_SECOND;
                state_nxt = S_SCALE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCALE: begin
        acc_x_nxt = sat32({{22{rnd_x[59]}}, rnd_x[59:16]});
        acc_y_nxt = sat32({{22{rnd_y[59]}}, rnd_y[59:16]});
        ang_acc_nxt = sat32({{22{rnd_a[59]}}, rnd_a[59:16]});
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        dp_x_nxt = acc_x_r * $signed({1'b0, dt2_r});
        dp_y_nxt = acc_y_r * $signed({1'b0, dt2_r});
        dp_a_nxt = ang_acc_r * $signed({1'b0, dt2_r});
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cur_x_nxt = sat32($signed({{33{cur_x_r[31]}}, cur_x_r, 1'b0})
                          - {{34{old_x_r[31]}}, old_x_r} + {{32{rd_x[65]}}, rd_x[65:32]});
        cur_y_nxt = sat32($signed({{33{cur_y_r[31]}}, cur_y_r, 1'b0})
                          - {{34{old_y_r[31]}}, old_y_r} + {{32{rd_y[65]}}, rd_y[65:32]});
        old_x_nxt = cur_x_r;
        old_y_nxt = cur_y_r;
        ang_prev_nxt = ang_now_r;
        rem_nxt = o_sum[33:0];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        quot_nxt = quot_prod[29:20];
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        ang_now_nxt = rem_r[24:0] - wrap_prod[24:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {6'd0, moving_r, acc_y_r, acc_x_r, ang_now_r, cur_y_r, cur_x_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_x_r <= '0; cur_y_r <= '0; old_x_r <= '0; old_y_r <= '0;
      ang_now_r <= '0; ang_prev_r <= '0;
      sum_x_r <= '0; sum_y_r <= '0; sum_a_r <= '0;
      acc_x_r <= '0; acc_y_r <= '0;
      still_r <= '0;
      moving_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_x_r <= cur_x_nxt; cur_y_r <= cur_y_nxt;
      old_x_r <= old_x_nxt; old_y_r <= old_y_nxt;
      ang_now_r <= ang_now_nxt; ang_prev_r <= ang_prev_nxt;
      sum_x_r <= sum_x_nxt; sum_y_r <= sum_y_nxt; sum_a_r <= sum_a_nxt;
      acc_x_r <= acc_x_nxt; acc_y_r <= acc_y_nxt;
      still_r <= still_nxt;
      moving_r <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt; prod_y_r <= prod_y_nxt; prod_a_r <= prod_a_nxt;
    dt2_r <= dt2_nxt; step_r <= step_nxt; ang_acc_r <= ang_acc_nxt;
    dp_x_r <= dp_x_nxt; dp_y_r <= dp_y_nxt; dp_a_r <= dp_a_nxt;
    rem_r <= rem_nxt; quot_r <= quot_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hdl/verlet_body_integrator_core.sv */
`default_nettype none
// Channel   Direction  Beat contents
// in_       slave      tuser: kind; tdata: value_x, value_y, time_step
// out_      master     tdata: pos_x, pos_y, orientation, accel_x, accel_y, awake
// cfg_      write      index 0 inverse_mass, 1 max_angular_step, 2 physics_enabled
// Force, torque, move and teleport beats retire in the idle state of the back end.
// A tick runs from the queue to the result register through the two multiply stages,
// the position update and the two-step orientation wrap; a frozen tick goes straight to emit.
// The two-entry input queue keeps accepting while the back end works or the result
// waits, and drops in_tready once it is full.
// Reset is synchronous and restores the body to rest at the origin, awake.
module verlet_body_integrator_core import vbi_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,   // value_x, value_y, time_step
  input  wire logic [2:0]   in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata,  // pos_x, pos_y, orientation, accel_x, accel_y, awake
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [25:0]  cfg_wdata
);

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recip_mass <= RECIP_MASS_RESET;
      cfg_r.max_step <= DEG360;
      cfg_r.enabled <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_INVERSE_MASS: cfg_r.recip_mass <= cfg_wdata;
        REG_MAX_ANGULAR_STEP: cfg_r.max_step <= cfg_wdata[24:0];
        REG_PHYSICS_ENABLED: cfg_r.enabled <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  vbi_front #(.DEPTH(QDEPTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  vbi_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef SYNTHESIS
  a_orient_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[88:64] < DEG360))
    else $error("orientation out of range");
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result pending after reset");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
